FILE: rtl/core/wcs_pkg.sv
// Shared types and constants for the weighted confidence smoother.
package wcs_pkg;

  // Q1.15 unity and rounding offset.
  localparam logic [15:0] OneQ15    = 16'd32768;
  localparam logic [14:0] RoundHalf = 15'd16384;

  // Crest mapping: (crest - 1.25) / 4.5 as ((crest - 5120) * 16 + 4) / 9.
  localparam logic [15:0] CrestKnee   = 16'd5120;
  localparam logic [19:0] CrestSatNum = 20'd294912;
  localparam logic [18:0] RecipNine   = 19'd466034;
  localparam int unsigned RecipNineSh = 22;

  // RMS mapping: rms / 0.12 as (rms * 25 + 1) / 3.
  localparam logic [20:0] RmsMul      = 21'd25;
  localparam logic [20:0] RmsBias     = 21'd1;
  localparam logic [20:0] RmsSatNum   = 21'd98304;
  localparam logic [16:0] RecipThree  = 17'd87382;
  localparam int unsigned RecipThreeSh = 18;

  // Stereo mapping: 1 - 0.65 * mono as 32768 - (mono * 13 + 10) / 20.
  localparam logic [19:0] MonoMul      = 20'd13;
  localparam logic [19:0] MonoBias     = 20'd10;
  localparam logic [19:0] MonoZeroNum  = 20'd655360;
  localparam logic [17:0] RecipFive    = 18'd209716;
  localparam int unsigned RecipFiveSh  = 20;

  // Q1.15 feature weights; they sum to one.
  localparam logic [13:0] WeightQuality = 14'd15073;
  localparam logic [13:0] WeightCrest   = 14'd7209;
  localparam logic [13:0] WeightRms     = 14'd5898;
  localparam logic [13:0] WeightStereo  = 14'd4588;

  // Recording modes. The fourth code behaves as studio.
  typedef enum logic [1:0] {
    ModeStudio    = 2'd0,
    ModeLive      = 2'd1,
    ModePhone     = 2'd2,
    ModeStudioAlt = 2'd3
  } wcs_mode_e;

  // Configuration register indexes.
  typedef enum logic {
    CfgAlphaDefault = 1'b0,
    CfgAlphaPhone   = 1'b1
  } wcs_cfg_e;

  // One classified frame as it travels from the front to the back.
  typedef struct packed {
    logic [15:0] quality;
    logic [15:0] crest;
    logic [15:0] rms;
    logic [15:0] stereo;
    wcs_mode_e   mode;
  } wcs_item_t;

  // Q1.15 gain applied for each recording mode.
  function automatic logic [15:0] mode_scale(input wcs_mode_e mode);
    logic [15:0] scale;
    case (mode)
      ModeStudio:    scale = 16'd32768;
      ModeLive:      scale = 16'd28836;
      ModePhone:     scale = 16'd24248;
      ModeStudioAlt: scale = 16'd32768;
      default:       scale = 16'd32768;
    endcase
    return scale;
  endfunction

endpackage

FILE: rtl/core/wcs_front.sv
// Front end: accepts frames and maps each feature to a clamped Q1.15 partial.
module wcs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [15:0]        crest_i,
  input  logic [15:0]        rms_level_i,
  input  logic [15:0]        mono_score_i,
  input  logic signed [16:0] quality_i,
  input  logic [1:0]         recording_mode_i,
  output logic               full_o,
  input  logic               q_full_i,
  output logic               item_valid_o,
  output wcs_pkg::wcs_item_t item_o
);
  import wcs_pkg::*;

  // Prepared numerators held between the two front stages.
  logic        valid_q;
  logic        crest_low_q;
  logic [19:0] crest_num_q;
  logic [20:0] rms_num_q;
  logic [19:0] mono_num_q;
  logic [15:0] quality_q;
  wcs_mode_e   mode_q;

  logic        take;
  logic        advance;
  logic [15:0] crest_diff;
  logic [15:0] quality_d;
  logic [37:0] crest_prod;
  logic [33:0] rms_prod;
  logic [35:0] mono_prod;
  logic [15:0] crest_part;
  logic [15:0] rms_part;
  logic [15:0] stereo_part;

  // The held frame moves on when the queue has room; a new one enters behind it.
  assign advance = valid_q && !q_full_i;
  assign full_o  = valid_q && q_full_i;
  assign take    = push_i && !full_o;

  // Negative quality reads as zero, anything above one as one.
  assign crest_diff = crest_i - CrestKnee;
  always_comb begin
    if (quality_i[16]) begin
      quality_d = 16'd0;
    end else if (quality_i[15:0] > OneQ15) begin
      quality_d = OneQ15;
    end else begin
      quality_d = quality_i[15:0];
    end
  end

  // First stage: numerators of the constant divisions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      crest_low_q <= (crest_i <= CrestKnee);
      crest_num_q <= {crest_diff, 4'b0100};
      rms_num_q   <= {5'd0, rms_level_i} * RmsMul + RmsBias;
      mono_num_q  <= {4'd0, mono_score_i} * MonoMul + MonoBias;
      quality_q   <= quality_d;
      mode_q      <= wcs_mode_e'(recording_mode_i);
    end
  end

  // Second stage: divisions by reciprocal multiplication, exact below saturation.
  assign crest_prod = 38'(crest_num_q[18:0]) * 38'(RecipNine);
  assign rms_prod   = 34'(rms_num_q[16:0]) * 34'(RecipThree);
  assign mono_prod  = 36'(mono_num_q[19:2]) * 36'(RecipFive);

  always_comb begin
    if (crest_low_q) begin
      crest_part = 16'd0;
    end else if (crest_num_q >= CrestSatNum) begin
      crest_part = OneQ15;
    end else begin
      crest_part = crest_prod[RecipNineSh +: 16];
    end

    if (rms_num_q >= RmsSatNum) begin
      rms_part = OneQ15;
    end else begin
      rms_part = rms_prod[RecipThreeSh +: 16];
    end

    // Dividing by 20 is a shift by two and a division by five.
    if (mono_num_q >= MonoZeroNum) begin
      stereo_part = 16'd0;
    end else begin
      stereo_part = OneQ15 - mono_prod[RecipFiveSh +: 16];
    end
  end

  assign item_valid_o   = advance;
  assign item_o.quality = quality_q;
  assign item_o.crest   = crest_part;
  assign item_o.rms     = rms_part;
  assign item_o.stereo  = stereo_part;
  assign item_o.mode    = mode_q;

endmodule

FILE: rtl/core/wcs_fifo.sv
// Small register queue that decouples the front end from the back end.
module wcs_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  wcs_pkg::wcs_item_t wr_data_i,
  output logic               full_o,
  input  logic               rd_en_i,
  output logic               empty_o,
  output wcs_pkg::wcs_item_t rd_data_o
);
  import wcs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  wcs_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr;
  logic            do_rd;

  assign full_o    = (count_q == FullCnt);
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Pointers wrap at the last entry; the count tracks occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/core/wcs_back.sv
// Back end: weighted sum, mode scaling and the one-pole smoother.
module wcs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  wcs_pkg::wcs_item_t item_i,
  output logic               item_pop_o,
  input  logic [15:0]        alpha_default_i,
  input  logic [15:0]        alpha_phone_i,
  output logic               res_valid_o,
  output logic [15:0]        res_o,
  input  logic               res_pop_i
);
  import wcs_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StSum,
    StScale,
    StTarget,
    StBlend,
    StMix
  } state_e;

  state_e      state_q;
  logic [15:0] smoothed_q;
  logic        res_valid_q;
  logic [15:0] res_q;
  wcs_mode_e   mode_q;
  logic [29:0] prod_quality_q;
  logic [29:0] prod_crest_q;
  logic [29:0] prod_rms_q;
  logic [29:0] prod_stereo_q;
  logic [15:0] sum_q;
  logic [31:0] scaled_q;
  logic [15:0] target_q;
  logic [31:0] keep_q;
  logic [31:0] fresh_q;

  logic        slot_free;
  logic        finish;
  logic        load;
  logic [30:0] sum_total;
  logic [15:0] sum_d;
  logic [32:0] target_total;
  logic [15:0] target_d;
  logic [15:0] alpha_raw;
  logic [15:0] alpha;
  logic [31:0] mix_total;
  logic [15:0] mix_d;

  // The result slot frees up when the waiting result is taken.
  assign slot_free  = !res_valid_q || res_pop_i;
  assign finish     = (state_q == StMix) && slot_free;
  assign load       = item_valid_i && ((state_q == StIdle) || finish);
  assign item_pop_o = load;

  // Rounded weighted sum, clamped to one.
  assign sum_total = 31'(prod_quality_q) + 31'(prod_crest_q) + 31'(prod_rms_q)
                   + 31'(prod_stereo_q) + 31'(RoundHalf);
  assign sum_d     = (sum_total[30:15] > OneQ15) ? OneQ15 : sum_total[30:15];

  // Rounded mode-scaled target, clamped to one.
  assign target_total = {1'b0, scaled_q} + 33'(RoundHalf);
  assign target_d     = (target_total[32:15] > 18'(OneQ15)) ? OneQ15
                                                            : target_total[30:15];

  // Phone mode has its own smoothing factor; factors above one act as one.
  assign alpha_raw = (mode_q == ModePhone) ? alpha_phone_i : alpha_default_i;
  assign alpha     = (alpha_raw > OneQ15) ? OneQ15 : alpha_raw;

  // Rounded blend of the previous level and the target.
  assign mix_total = keep_q + fresh_q + 32'(RoundHalf);
  assign mix_d     = (mix_total[31:15] > 17'(OneQ15)) ? OneQ15 : mix_total[30:15];

  // Sequencer with its registered outputs and smoother state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      smoothed_q  <= 16'd0;
      res_valid_q <= 1'b0;
      res_q       <= 16'd0;
    end else begin
      // A new result replaces the one taken in the same cycle.
      if (finish) begin
        smoothed_q  <= mix_d;
        res_q       <= mix_d;
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (load) begin
            state_q <= StSum;
          end
        end
        StSum:    state_q <= StScale;
        StScale:  state_q <= StTarget;
        StTarget: state_q <= StBlend;
        StBlend:  state_q <= StMix;
        StMix: begin
          if (finish) begin
            state_q <= load ? StSum : StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath registers, one multiply stage at a time.
  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q         <= item_i.mode;
      prod_quality_q <= 30'(item_i.quality) * 30'(WeightQuality);
      prod_crest_q   <= 30'(item_i.crest) * 30'(WeightCrest);
      prod_rms_q     <= 30'(item_i.rms) * 30'(WeightRms);
      prod_stereo_q  <= 30'(item_i.stereo) * 30'(WeightStereo);
    end
    if (state_q == StSum) begin
      sum_q <= sum_d;
    end
    if (state_q == StScale) begin
      scaled_q <= 32'(sum_q) * 32'(mode_scale(mode_q));
    end
    if (state_q == StTarget) begin
      target_q <= target_d;
    end
    if (state_q == StBlend) begin
      keep_q  <= 32'(alpha) * 32'(smoothed_q);
      fresh_q <= 32'(OneQ15 - alpha) * 32'(target_q);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/core/weighted_confidence_smoother_unit.sv
// A frame passes the front-end stage register and the queue, then the back-end sequencer's
//   sum, scale, target, blend and mix steps, and its result waits in an output register.
// The back end takes a new frame only as it finishes the last; the front end and the queue
//   run ahead while it works, and a result not yet taken holds it in its last step.
// Reset clears the smoothed level to zero, empties the queue and loads the default
//   smoothing factors (31344 for studio and live, 31812 for phone).
module weighted_confidence_smoother_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Frame input.
  input  logic               push,
  output logic               full,
  input  logic [15:0]        crest_i,
  input  logic [15:0]        rms_level_i,
  input  logic [15:0]        mono_score_i,
  input  logic signed [16:0] quality_i,
  input  logic [1:0]         recording_mode_i,
  // Result output.
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        confidence_o,
  // Configuration writes.
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import wcs_pkg::*;

  logic        front_valid;
  wcs_item_t   front_item;
  logic        q_full;
  logic        q_empty;
  wcs_item_t   q_item;
  logic        q_pop;
  logic [15:0] alpha_default_q;
  logic [15:0] alpha_phone_q;
  logic        res_valid;

  // Smoothing factor registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_default_q <= 16'd31344;
      alpha_phone_q   <= 16'd31812;
    end else if (cfg_we_i) begin
      case (wcs_cfg_e'(cfg_idx_i))
        CfgAlphaDefault: alpha_default_q <= cfg_wdata_i;
        CfgAlphaPhone:   alpha_phone_q   <= cfg_wdata_i;
        default:         alpha_default_q <= alpha_default_q;
      endcase
    end
  end

  wcs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .crest_i          (crest_i),
    .rms_level_i      (rms_level_i),
    .mono_score_i     (mono_score_i),
    .quality_i        (quality_i),
    .recording_mode_i (recording_mode_i),
    .full_o           (full),
    .q_full_i         (q_full),
    .item_valid_o     (front_valid),
    .item_o           (front_item)
  );

  wcs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (front_valid),
    .wr_data_i (front_item),
    .full_o    (q_full),
    .rd_en_i   (q_pop),
    .empty_o   (q_empty),
    .rd_data_o (q_item)
  );

  wcs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (!q_empty),
    .item_i          (q_item),
    .item_pop_o      (q_pop),
    .alpha_default_i (alpha_default_q),
    .alpha_phone_i   (alpha_phone_q),
    .res_valid_o     (res_valid),
    .res_o           (confidence_o),
    .res_pop_i       (pop && res_valid)
  );

  assign empty = !res_valid;

endmodule
